[hdl/cdqs_pkg.sv]
package cdqs_pkg;

  // Widths of the command and result fields.
  localparam int unsigned ModeW   = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CountW  = 5;

  // Command codes. The unused code is handled as a search.
  localparam logic [ModeW-1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [ModeW-1:0] MODE_PUSH_BACK  = 2'd1;
  localparam logic [ModeW-1:0] MODE_SEARCH     = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_INSERTED  = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd1;
  localparam logic [StatusW-1:0] ST_FOUND     = 2'd2;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd3;

endpackage

[hdl/circular_deque_with_search_core.sv]
// Bounded deque of signed 32-bit words, held as a ring in a single-port-write,
// registered-read memory of CAPACITY entries with a front index and a count.
// A command is taken when start is high and busy is low. A push to the
// front or back is answered in the next cycle; a push into a full deque is
// refused with a full status and changes nothing. A search checks the last
// element first and then the others from front to back, comparing one
// stored word per cycle through the one ring address adder and one 32-bit
// comparator; it keeps busy high until its result is shown. A search of an
// empty deque returns not found without raising busy. Each command yields
// exactly one result, shown on status_o, position_o and count_o for the
// single cycle in which done_o is high; the receiver cannot stall it.
// position_o carries low index bits if CAPACITY > 16, count_o if it is > 31.
module circular_deque_with_search_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [cdqs_pkg::ModeW-1:0]         mode_i,
  input  logic signed [cdqs_pkg::ValueW-1:0] value_i,
  output logic                               done_o,
  output logic [cdqs_pkg::StatusW-1:0]       status_o,
  output logic [cdqs_pkg::PosW-1:0]          position_o,
  output logic [cdqs_pkg::CountW-1:0]        count_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  localparam logic [IdxW:0]   CapSum  = (IdxW + 1)'(CAPACITY);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);
  localparam logic [CntW-1:0] CapCnt  = CntW'(CAPACITY);

  // Sequencer states.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state_q, state_d;
  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;

  // Scan bookkeeping: next offset to read, reads left, and the word in flight.
  logic [IdxW-1:0] ofs_q, ofs_d;
  logic            first_q, first_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_ofs_q, pend_ofs_d;
  logic signed [cdqs_pkg::ValueW-1:0] key_q;

  // Result register.
  logic                          done_q, done_d;
  logic [cdqs_pkg::StatusW-1:0]  status_q, status_d;
  logic [IdxW-1:0]               pos_q, pos_d;

  // Ring storage.
  logic signed [cdqs_pkg::ValueW-1:0] mem_q [CAPACITY];
  logic signed [cdqs_pkg::ValueW-1:0] rd_data_q;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;

  // Shared ring address unit: front plus offset, wrapped once.
  logic [IdxW-1:0] addr_ofs;
  logic [IdxW:0]   addr_sum;
  logic [IdxW-1:0] ring_addr;
  logic            accept;
  logic            is_push;
  logic            is_full;
  logic [IdxW-1:0] front_dec;

  assign accept  = start && (state_q == S_IDLE);
  assign is_push = (mode_i == cdqs_pkg::MODE_PUSH_FRONT) ||
                   (mode_i == cdqs_pkg::MODE_PUSH_BACK);
  assign is_full = (count_q >= CapCnt);

  assign addr_ofs  = (state_q == S_IDLE) ? count_q[IdxW-1:0] : ofs_q;
  assign addr_sum  = {1'b0, front_q} + {1'b0, addr_ofs};
  assign ring_addr = (addr_sum >= CapSum) ? IdxW'(addr_sum - CapSum) : addr_sum[IdxW-1:0];
  assign front_dec = (front_q == '0) ? LastIdx : front_q - 1'b1;

  // Sequencer and datapath control.
  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    count_d    = count_q;
    ofs_d      = ofs_q;
    first_d    = first_q;
    rem_d      = rem_q;
    pend_d     = 1'b0;
    pend_ofs_d = pend_ofs_q;
    done_d     = 1'b0;
    status_d   = status_q;
    pos_d      = '0;
    wr_en      = 1'b0;
    wr_addr    = ring_addr;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          if (is_push) begin
            if (is_full) begin
              status_d = cdqs_pkg::ST_FULL;
            end else begin
              status_d = cdqs_pkg::ST_INSERTED;
              wr_en    = 1'b1;
              count_d  = count_q + 1'b1;
              if (mode_i == cdqs_pkg::MODE_PUSH_FRONT) begin
                front_d = front_dec;
                wr_addr = front_dec;
              end
            end
          end else if (count_q == '0) begin
            status_d = cdqs_pkg::ST_NOT_FOUND;
          end else begin
            // Start with the last element.
            done_d  = 1'b0;
            state_d = S_SCAN;
            ofs_d   = IdxW'(count_q - 1'b1);
            first_d = 1'b1;
            rem_d   = count_q;
          end
        end
      end
      S_SCAN: begin
        // Issue the next read while comparing the word read last cycle.
        if (rem_q != '0) begin
          pend_d     = 1'b1;
          pend_ofs_d = ofs_q;
          rem_d      = rem_q - 1'b1;
          first_d    = 1'b0;
          ofs_d      = first_q ? '0 : ofs_q + 1'b1;
        end
        if (pend_q && (rd_data_q == key_q)) begin
          pend_d   = 1'b0;
          done_d   = 1'b1;
          status_d = cdqs_pkg::ST_FOUND;
          pos_d    = pend_ofs_q;
          state_d  = S_IDLE;
        end else if (pend_q && (rem_q == '0)) begin
          done_d   = 1'b1;
          status_d = cdqs_pkg::ST_NOT_FOUND;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
      first_q <= 1'b0;
      rem_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      first_q <= first_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ofs_q      <= ofs_d;
    pend_ofs_q <= pend_ofs_d;
    status_q   <= status_d;
    pos_q      <= pos_d;
    if (accept) begin
      key_q <= value_i;
    end
  end

  // Ring memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= value_i;
    end
    rd_data_q <= mem_q[ring_addr];
  end

  // Outputs.
  logic [31:0] pos_ext;
  logic [31:0] cnt_ext;

  assign pos_ext    = 32'(pos_q);
  assign cnt_ext    = 32'(count_q);
  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign position_o = pos_ext[cdqs_pkg::PosW-1:0];
  assign count_o    = cnt_ext[cdqs_pkg::CountW-1:0];

  // The element count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("element count above capacity");

  // A scan only runs over a non-empty deque.
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (count_q != '0))
    else $error("scan running on an empty deque");

  // A found position lies inside the held elements.
  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == cdqs_pkg::ST_FOUND)) |-> (CntW'(pos_q) < count_q))
    else $error("found position outside the deque");

  // A successful push grows the count by exactly one.
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == cdqs_pkg::ST_INSERTED)) |-> (count_q == $past(count_q) + 1'b1))
    else $error("push did not grow the count by one");

  // A refused push leaves the count at capacity.
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == cdqs_pkg::ST_FULL)) |-> (count_q == CapCnt))
    else $error("full status while the deque has room");

endmodule
